// ===== sv/block_growing_handle_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Block growing handle allocator: assertion macros
// Shared concurrent assertion forms, clocked on aclk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_GROWING_HANDLE_ALLOCATOR_MACROS_SVH
`define BLOCK_GROWING_HANDLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BGHA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BGHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bgha_pkg.sv =====
// ----------------------------------------------------------------------------
// Block growing handle allocator package
// Request and response types, field widths and operation codes.
// ----------------------------------------------------------------------------
package bgha_pkg;

    localparam int HANDLE_W  = 10;
    localparam int EPB_W     = 9;
    localparam int MAXB_W    = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;
    // block base: blocks_opened (7 bits) times block size (9 bits)
    localparam int BASE_W    = 16;
    // base plus block size, and pool limits up to 65536
    localparam int WIDE_W    = 17;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_PER_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS        = 1'b1;

    localparam logic [EPB_W-1:0]  EPB_RESET  = 9'd16;
    localparam logic [MAXB_W-1:0] MAXB_RESET = 7'd16;

    typedef struct packed {
        logic                func;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                granted;
    } rsp_t;

endpackage

// ===== sv/block_growing_handle_allocator.sv =====
// Sequence: a free request goes from S_IDLE to S_DONE; an allocate goes through S_ALLOC,
//   then S_OPEN to open a block or S_READ for the registered free FIFO read, then S_DONE.
// Requests: one at a time; s_ready is high only in S_IDLE, so a new request waits until
//   the last one leaves S_DONE, which itself waits on room in the output register.
// Reset: control state, pointers and counters clear; entries_per_block and max_blocks
//   return to 16. FIFO memory contents are not cleared, as a pop needs a nonzero count.
// ----------------------------------------------------------------------------
// Block growing handle allocator
// Hands out object handles from the open block, then from a FIFO of freed handles kept
// in a synchronous single-port-per-side memory, and opens new blocks only when both are dry.
// ----------------------------------------------------------------------------
`include "block_growing_handle_allocator_macros.svh"

module block_growing_handle_allocator #(
    parameter int unsigned POOL_ENTRIES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  bgha_pkg::req_t                   s_payload,
    // response channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output bgha_pkg::rsp_t                   m_payload,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [bgha_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [bgha_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int PTR_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_ENTRIES);
    localparam logic [bgha_pkg::WIDE_W-1:0] POOL_LIMIT = bgha_pkg::WIDE_W'(POOL_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_OPEN,
        S_READ,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                            state_reg, state_next;
    bgha_pkg::req_t                    req_reg, req_next;
    bgha_pkg::rsp_t                    res_reg, res_next;
    logic                              m_valid_reg, m_valid_next;
    bgha_pkg::rsp_t                    m_payload_reg, m_payload_next;

    logic [bgha_pkg::EPB_W-1:0]        entries_per_block_reg, entries_per_block_next;
    logic [bgha_pkg::MAXB_W-1:0]       max_blocks_reg, max_blocks_next;

    logic [PTR_W-1:0]                  fifo_head_reg, fifo_head_next;
    logic [PTR_W-1:0]                  fifo_tail_reg, fifo_tail_next;
    logic [CNT_W-1:0]                  fifo_count_reg, fifo_count_next;
    logic [bgha_pkg::MAXB_W-1:0]       blocks_opened_reg, blocks_opened_next;
    logic [bgha_pkg::EPB_W-1:0]        fresh_left_reg, fresh_left_next;
    logic [bgha_pkg::BASE_W-1:0]       fresh_base_reg, fresh_base_next;
    logic [bgha_pkg::BASE_W-1:0]       prod_reg, prod_next;

    // free FIFO memory
    logic [bgha_pkg::HANDLE_W-1:0]     fifo_mem [POOL_ENTRIES];
    logic [bgha_pkg::HANDLE_W-1:0]     mem_rd_data_reg;
    logic                              mem_wr_en;
    logic                              mem_rd_en;

    // ------------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------------
    logic                              s_fire;
    logic                              slot_free;
    logic                              need_open;
    logic [bgha_pkg::WIDE_W-1:0]       fresh_hnd;
    logic [bgha_pkg::WIDE_W-1:0]       open_top;
    logic [bgha_pkg::WIDE_W-1:0]       open_lim;
    logic [bgha_pkg::EPB_W-1:0]        open_left;
    logic [bgha_pkg::WIDE_W-1:0]       open_hnd;
    logic [PTR_W-1:0]                  head_inc;
    logic [PTR_W-1:0]                  tail_inc;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // wrap pointers at the pool size, which need not be a power of two
    assign head_inc = (fifo_head_reg == PTR_LAST) ? '0 : fifo_head_reg + PTR_W'(1);
    assign tail_inc = (fifo_tail_reg == PTR_LAST) ? '0 : fifo_tail_reg + PTR_W'(1);

    // open a block only when both sources are dry and the block budget allows
    assign need_open = (fresh_left_reg == '0) && (fifo_count_reg == '0)
                    && (blocks_opened_reg < max_blocks_reg);

    // next fresh handle, highest of the block first
    assign fresh_hnd = bgha_pkg::WIDE_W'(fresh_base_reg) + bgha_pkg::WIDE_W'(fresh_left_reg)
                     - bgha_pkg::WIDE_W'(1);

    // block range from the registered product, clipped at the pool end
    assign open_top  = bgha_pkg::WIDE_W'(prod_reg) + bgha_pkg::WIDE_W'(entries_per_block_reg);
    assign open_lim  = (open_top > POOL_LIMIT) ? POOL_LIMIT : open_top;
    assign open_left = (open_lim > bgha_pkg::WIDE_W'(prod_reg))
                     ? bgha_pkg::EPB_W'(open_lim - bgha_pkg::WIDE_W'(prod_reg)) : '0;
    assign open_hnd  = bgha_pkg::WIDE_W'(prod_reg) + bgha_pkg::WIDE_W'(open_left)
                     - bgha_pkg::WIDE_W'(1);

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb begin
        state_next             = state_reg;
        req_next               = req_reg;
        res_next               = res_reg;
        m_valid_next           = m_valid_reg;
        m_payload_next         = m_payload_reg;
        entries_per_block_next = entries_per_block_reg;
        max_blocks_next        = max_blocks_reg;
        fifo_head_next         = fifo_head_reg;
        fifo_tail_next         = fifo_tail_reg;
        fifo_count_next        = fifo_count_reg;
        blocks_opened_next     = blocks_opened_reg;
        fresh_left_next        = fresh_left_reg;
        fresh_base_next        = fresh_base_reg;
        prod_next              = prod_reg;
        mem_wr_en              = 1'b0;
        mem_rd_en              = 1'b0;

        // configuration writes land whenever enabled
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                bgha_pkg::REG_ENTRIES_PER_BLOCK: begin
                    entries_per_block_next = cfg_wdata[bgha_pkg::EPB_W-1:0];
                end
                bgha_pkg::REG_MAX_BLOCKS: begin
                    max_blocks_next = cfg_wdata[bgha_pkg::MAXB_W-1:0];
                end
                default: begin
                end
            endcase
        end

        // drop the response once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    req_next = s_payload;
                    if (s_payload.func == bgha_pkg::FUNC_FREE) begin
                        // push unless the FIFO is full; a free always answers zero
                        if (fifo_count_reg < CNT_FULL) begin
                            mem_wr_en       = 1'b1;
                            fifo_tail_next  = tail_inc;
                            fifo_count_next = fifo_count_reg + CNT_W'(1);
                        end
                        res_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                priority if (need_open) begin
                    prod_next  = bgha_pkg::BASE_W'(blocks_opened_reg)
                               * bgha_pkg::BASE_W'(entries_per_block_reg);
                    state_next = S_OPEN;
                end else if (fresh_left_reg != '0) begin
                    res_next.handle_out = fresh_hnd[bgha_pkg::HANDLE_W-1:0];
                    res_next.granted    = 1'b1;
                    fresh_left_next     = fresh_left_reg - bgha_pkg::EPB_W'(1);
                    state_next          = S_DONE;
                end else if (fifo_count_reg != '0) begin
                    mem_rd_en  = 1'b1;
                    state_next = S_READ;
                end else begin
                    // pool exhausted
                    res_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_OPEN: begin
                fresh_base_next    = prod_reg;
                blocks_opened_next = blocks_opened_reg + bgha_pkg::MAXB_W'(1);
                if (open_left != '0) begin
                    res_next.handle_out = open_hnd[bgha_pkg::HANDLE_W-1:0];
                    res_next.granted    = 1'b1;
                    fresh_left_next     = open_left - bgha_pkg::EPB_W'(1);
                end else begin
                    // empty block: still counted, nothing to grant (FIFO is empty here)
                    res_next        = '0;
                    fresh_left_next = '0;
                end
                state_next = S_DONE;
            end
            S_READ: begin
                res_next.handle_out = mem_rd_data_reg;
                res_next.granted    = 1'b1;
                fifo_head_next      = head_inc;
                fifo_count_next     = fifo_count_reg - CNT_W'(1);
                state_next          = S_DONE;
            end
            S_DONE: begin
                // hold the response until the output register has room
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg             <= S_IDLE;
            m_valid_reg           <= 1'b0;
            entries_per_block_reg <= bgha_pkg::EPB_RESET;
            max_blocks_reg        <= bgha_pkg::MAXB_RESET;
            fifo_head_reg         <= '0;
            fifo_tail_reg         <= '0;
            fifo_count_reg        <= '0;
            blocks_opened_reg     <= '0;
            fresh_left_reg        <= '0;
            fresh_base_reg        <= '0;
        end else begin
            state_reg             <= state_next;
            m_valid_reg           <= m_valid_next;
            entries_per_block_reg <= entries_per_block_next;
            max_blocks_reg        <= max_blocks_next;
            fifo_head_reg         <= fifo_head_next;
            fifo_tail_reg         <= fifo_tail_next;
            fifo_count_reg        <= fifo_count_next;
            blocks_opened_reg     <= blocks_opened_next;
            fresh_left_reg        <= fresh_left_next;
            fresh_base_reg        <= fresh_base_next;
        end
        req_reg       <= req_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
        prod_reg      <= prod_next;
    end

    // ------------------------------------------------------------------------
    // Free FIFO memory: write at the tail, registered read at the head
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            fifo_mem[fifo_tail_reg] <= req_next.handle_in;
        end
        if (mem_rd_en) begin
            mem_rd_data_reg <= fifo_mem[fifo_head_reg];
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BGHA_ASSERT_IMPL(a_count_bound, 1'b1, fifo_count_reg <= CNT_FULL, "free FIFO count above pool size")
    `BGHA_ASSERT_IMPL(a_pop_nonempty, mem_rd_en, fifo_count_reg != '0, "pop from empty free FIFO")
    `BGHA_ASSERT_NEXT(a_pop_count, state_reg == S_READ, fifo_count_reg == $past(fifo_count_reg) - CNT_W'(1), "pop did not decrement FIFO count")
    `BGHA_ASSERT_IMPL(a_fresh_needs_block, fresh_left_reg != '0, blocks_opened_reg != '0, "fresh handles with no block opened")
    `BGHA_ASSERT_IMPL(a_denied_zero, m_valid_reg && !m_payload_reg.granted, m_payload_reg.handle_out == '0, "ungranted response carries a handle")

endmodule
